/* rtl/thi_pkg.sv */
// types, codes and helpers shared by the trajectory hermite interpolator
// no dependencies; used by thi_ctrl, thi_dp and the top level
package thi_pkg;

    localparam int ONE_Q16   = 65536;
    localparam int DIV_STEPS = 16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [53:0] MAX32 = 54'sd2147483647;
    localparam logic signed [53:0] MIN32 = -54'sd2147483648;

    typedef struct packed {
        logic signed [31:0] stamp;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } row_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD_LAST, S_CHECK, S_WALK_RD, S_WALK_CHK, S_GET_A,
        S_DIV_INIT, S_DIV_STEP, S_DIV_FIN, S_MUL_ISSUE, S_MUL_WB, S_FINISH
    } state_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_LATCH, DP_LOAD_WR, DP_DROP, DP_EMPTY, DP_RD_FIRST, DP_RD_LAST,
        DP_HOLD_FIRST, DP_HOLD_LAST, DP_WALK_INIT, DP_WALK_RD, DP_WALK_STEP,
        DP_WALK_END, DP_GET_A, DP_DIV_INIT, DP_DIV_STEP, DP_DIV_FIN,
        DP_MUL_ISSUE, DP_MUL_WB, DP_COMMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        M_T2, M_T3, M_WA, M_WB, M_P0, M_V0, M_P1, M_V1, M_LERP
    } mul_op_t;

    typedef struct packed {
        dp_op_t      op;
        mul_op_t     mop;
        logic [1:0]  axis;
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic body_ok;
        logic empty;
        logic full;
        logic before_first;
        logic after_last;
        logic walk_more;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [53:0] x);
        logic signed [31:0] r;
        if (x > MAX32)
            r = 32'sh7fffffff;
        else if (x < MIN32)
            r = 32'sh80000000;
        else
            r = 32'(x);
        return r;
    endfunction

endpackage

/* rtl/thi_ctrl.sv */
// sequencing state machine of the trajectory hermite interpolator
// depends on thi_pkg; drives thi_dp through dp_cmd_t, reads dp_stat_t
module thi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_ready,
    input  thi_pkg::dp_stat_t stat,
    output logic             in_ready,
    output logic             out_valid,
    output thi_pkg::dp_cmd_t ctl
);
    import thi_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] div_cnt_reg, div_cnt_next;
    mul_op_t    mop_reg, mop_next;
    logic [1:0] axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;
    logic       commit;

    assign commit = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            mop_reg       <= M_T2;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            mop_reg       <= mop_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        mop_next       = mop_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
                if (!stat.is_query || !stat.body_ok || stat.empty)
                    state_next = S_FINISH;
                else
                    state_next = S_RD_LAST;
            S_RD_LAST:
                state_next = S_CHECK;
            S_CHECK:
                if (stat.before_first || stat.after_last)
                    state_next = S_FINISH;
                else
                    state_next = S_WALK_RD;
            S_WALK_RD:
                state_next = S_WALK_CHK;
            S_WALK_CHK:
                if (stat.walk_more)
                    state_next = S_WALK_RD;
                else
                    state_next = S_GET_A;
            S_GET_A:
                state_next = S_DIV_INIT;
            S_DIV_INIT:
            begin
                div_cnt_next = '0;
                state_next   = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'(DIV_STEPS - 1))
                    state_next = S_DIV_FIN;
            end
            S_DIV_FIN:
            begin
                mop_next   = M_T2;
                axis_next  = '0;
                state_next = S_MUL_ISSUE;
            end
            S_MUL_ISSUE:
                state_next = S_MUL_WB;
            S_MUL_WB:
            begin
                state_next = S_MUL_ISSUE;
                unique case (mop_reg)
                    M_T2:   mop_next = M_T3;
                    M_T3:   mop_next = M_WA;
                    M_WA:   mop_next = M_WB;
                    M_WB:   mop_next = M_P0;
                    M_P0:   mop_next = M_V0;
                    M_V0:   mop_next = M_P1;
                    M_P1:   mop_next = M_V1;
                    M_V1:   mop_next = M_LERP;
                    M_LERP:
                    begin
                        mop_next  = M_P0;
                        axis_next = axis_reg + 2'd1;
                        if (axis_reg == 2'd2)
                            state_next = S_FINISH;
                    end
                    default: mop_next = M_T2;
                endcase
            end
            S_FINISH:
                if (commit)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        ctl.op   = DP_NOP;
        ctl.mop  = mop_reg;
        ctl.axis = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    ctl.op = DP_LATCH;
            end
            S_DECODE:
                if (!stat.is_query)
                    ctl.op = (stat.body_ok && !stat.full) ? DP_LOAD_WR : DP_DROP;
                else if (!stat.body_ok || stat.empty)
                    ctl.op = DP_EMPTY;
                else
                    ctl.op = DP_RD_FIRST;
            S_RD_LAST:
                ctl.op = DP_RD_LAST;
            S_CHECK:
                if (stat.before_first)
                    ctl.op = DP_HOLD_FIRST;
                else if (stat.after_last)
                    ctl.op = DP_HOLD_LAST;
                else
                    ctl.op = DP_WALK_INIT;
            S_WALK_RD:
                ctl.op = DP_WALK_RD;
            S_WALK_CHK:
                ctl.op = stat.walk_more ? DP_WALK_STEP : DP_WALK_END;
            S_GET_A:
                ctl.op = DP_GET_A;
            S_DIV_INIT:
                ctl.op = DP_DIV_INIT;
            S_DIV_STEP:
                ctl.op = DP_DIV_STEP;
            S_DIV_FIN:
                ctl.op = DP_DIV_FIN;
            S_MUL_ISSUE:
                ctl.op = DP_MUL_ISSUE;
            S_MUL_WB:
                ctl.op = DP_MUL_WB;
            S_FINISH:
                if (commit)
                    ctl.op = DP_COMMIT;
            default:
                ctl.op = DP_NOP;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/thi_dp.sv */
// datapath: sample memory, per-body counts and cursors, divider, shared multiplier
// depends on thi_pkg; commanded by thi_ctrl
module thi_dp #(
    parameter int BODIES  = 10,
    parameter int SAMPLES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  thi_pkg::dp_cmd_t    ctl,
    output thi_pkg::dp_stat_t   stat,
    input  logic                cmd,
    input  logic [3:0]          body,
    input  logic signed [31:0]  sample_or_query_time,
    input  logic signed [31:0]  in_pos_x,
    input  logic signed [31:0]  in_pos_y,
    input  logic signed [31:0]  in_pos_z,
    input  logic signed [31:0]  in_vel_x,
    input  logic signed [31:0]  in_vel_y,
    input  logic signed [31:0]  in_vel_z,
    output logic [1:0]          status,
    output logic signed [31:0]  out_pos_x,
    output logic signed [31:0]  out_pos_y,
    output logic signed [31:0]  out_pos_z,
    output logic signed [31:0]  out_vel_x,
    output logic signed [31:0]  out_vel_y,
    output logic signed [31:0]  out_vel_z,
    output logic [9:0]          segment
);
    import thi_pkg::*;

    localparam int DEPTH = BODIES * SAMPLES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(SAMPLES);
    localparam int CW    = $clog2(SAMPLES + 1);
    localparam int CW1   = CW + 1;
    localparam int BIW   = (BODIES > 1) ? $clog2(BODIES) : 1;
    localparam int HW    = 21;

    // sample memory, one row per sample
    row_t mem [DEPTH];

    logic               cmd_reg;
    logic [3:0]         body_reg;
    logic signed [31:0] t_reg;
    row_t               in_row_reg;
    logic [CW-1:0]      loaded_reg [BODIES];
    logic [IW-1:0]      cursor_reg [BODIES];
    row_t               row_a_reg, row_b_reg, rd_row_reg;
    logic [IW-1:0]      idx_reg;
    logic [32:0]        div_rem_reg, div_dvs_reg;
    logic [16:0]        div_q_reg;
    logic               div_neg_reg, div_big_reg, div_zero_reg;
    logic signed [17:0] f_reg, t2_reg, t3_reg;
    logic signed [31:0] wa_reg, wb_reg;
    logic signed [67:0] prod_reg;
    logic signed [53:0] acc_reg;
    logic [1:0]         res_status_reg, out_status_reg;
    logic signed [31:0] res_pos_reg [3];
    logic signed [31:0] res_vel_reg [3];
    logic signed [31:0] out_pos_reg [3];
    logic signed [31:0] out_vel_reg [3];
    logic [9:0]         res_seg_reg, out_seg_reg;

    logic               body_ok;
    logic [BIW-1:0]     bidx;
    logic [CW-1:0]      n_cur, n_m2;
    logic [IW-1:0]      cur_c, idx_init;
    logic [AW-1:0]      base, mem_addr;
    logic               mem_we;
    logic signed [32:0] num, den, vdiff;
    logic [32:0]        an, dn;
    logic [33:0]        r2;
    logic [16:0]        mag;
    logic signed [HW-1:0] h00, h10, h01, h11;
    logic signed [33:0] ma, mb;
    logic signed [67:0] rsum;
    logic signed [51:0] rnd_val;
    logic signed [53:0] rnd54;
    logic signed [31:0] p0, p1, v0, v1;

    function automatic logic signed [31:0] pos_of(input row_t r, input logic [1:0] a);
        logic signed [31:0] v;
        case (a)
            2'd0:    v = r.pos_x;
            2'd1:    v = r.pos_y;
            default: v = r.pos_z;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] vel_of(input row_t r, input logic [1:0] a);
        logic signed [31:0] v;
        case (a)
            2'd0:    v = r.vel_x;
            2'd1:    v = r.vel_y;
            default: v = r.vel_z;
        endcase
        return v;
    endfunction

    assign body_ok = int'(body_reg) < BODIES;
    assign bidx    = BIW'(body_reg);
    assign n_cur   = body_ok ? loaded_reg[bidx] : '0;
    assign cur_c   = body_ok ? cursor_reg[bidx] : '0;
    assign n_m2    = n_cur - CW'(2);
    assign idx_init = (CW'(cur_c) > n_m2) ? IW'(n_m2) : cur_c;
    assign base    = AW'(bidx) * AW'(SAMPLES);

    assign stat.is_query     = cmd_reg;
    assign stat.body_ok      = body_ok;
    assign stat.empty        = (n_cur == '0);
    assign stat.full         = (n_cur >= CW'(SAMPLES));
    assign stat.before_first = (t_reg <= row_a_reg.stamp);
    assign stat.after_last   = (t_reg >= rd_row_reg.stamp);
    assign stat.walk_more    = (CW1'(idx_reg) + CW1'(2) < CW1'(n_cur))
                               && (rd_row_reg.stamp < t_reg);

    // memory address by operation
    always_comb
    begin
        mem_we = (ctl.op == DP_LOAD_WR);
        unique case (ctl.op)
            DP_RD_LAST:  mem_addr = base + AW'(n_cur - CW'(1));
            DP_WALK_RD:  mem_addr = base + AW'(idx_reg) + AW'(1);
            DP_WALK_END: mem_addr = base + AW'(idx_reg);
            DP_LOAD_WR:  mem_addr = base + AW'(n_cur);
            default:     mem_addr = base;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= in_row_reg;
        rd_row_reg <= mem[mem_addr];
    end

    // segment arithmetic
    assign num   = 33'(t_reg) - 33'(row_a_reg.stamp);
    assign den   = 33'(row_b_reg.stamp) - 33'(row_a_reg.stamp);
    assign an    = num[32] ? 33'(-num) : 33'(num);
    assign dn    = den[32] ? 33'(-den) : 33'(den);
    assign r2    = {div_rem_reg, 1'b0};
    assign mag   = (div_big_reg || div_q_reg > 17'd65536) ? 17'd65536 : div_q_reg;

    assign h00 = HW'(2 * t3_reg - 3 * t2_reg + ONE_Q16);
    assign h10 = HW'(t3_reg - 2 * t2_reg + f_reg);
    assign h01 = HW'(3 * t2_reg - 2 * t3_reg);
    assign h11 = HW'(t3_reg - t2_reg);

    assign p0    = pos_of(row_a_reg, ctl.axis);
    assign p1    = pos_of(row_b_reg, ctl.axis);
    assign v0    = vel_of(row_a_reg, ctl.axis);
    assign v1    = vel_of(row_b_reg, ctl.axis);
    assign vdiff = 33'(v1) - 33'(v0);

    // shared multiplier operands
    always_comb
    begin
        case (ctl.mop)
            M_T2:    begin ma = 34'(f_reg);  mb = 34'(f_reg); end
            M_T3:    begin ma = 34'(t2_reg); mb = 34'(f_reg); end
            M_WA:    begin ma = 34'(h10);    mb = 34'(den);   end
            M_WB:    begin ma = 34'(h11);    mb = 34'(den);   end
            M_P0:    begin ma = 34'(h00);    mb = 34'(p0);    end
            M_V0:    begin ma = 34'(wa_reg); mb = 34'(v0);    end
            M_P1:    begin ma = 34'(h01);    mb = 34'(p1);    end
            M_V1:    begin ma = 34'(wb_reg); mb = 34'(v1);    end
            M_LERP:  begin ma = 34'(f_reg);  mb = 34'(vdiff); end
            default: begin ma = '0;          mb = '0;         end
        endcase
    end

    // round half up back to q16.16
    assign rsum    = prod_reg + 68'sd32768;
    assign rnd_val = rsum[67:16];
    assign rnd54   = 54'(rnd_val);

    // per-body counts and cursors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BODIES; i++)
            begin
                loaded_reg[i] <= '0;
                cursor_reg[i] <= '0;
            end
        end
        else if (ctl.op == DP_LOAD_WR)
            loaded_reg[bidx] <= n_cur + CW'(1);
        else if (ctl.op == DP_WALK_END)
            cursor_reg[bidx] <= idx_reg;
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            DP_LATCH:
            begin
                cmd_reg    <= cmd;
                body_reg   <= body;
                t_reg      <= sample_or_query_time;
                in_row_reg <= '{sample_or_query_time, in_pos_x, in_pos_y, in_pos_z,
                                in_vel_x, in_vel_y, in_vel_z};
            end
            DP_LOAD_WR, DP_DROP, DP_EMPTY:
            begin
                res_status_reg <= (ctl.op == DP_LOAD_WR) ? ST_OK
                                : (ctl.op == DP_DROP) ? ST_DROP : ST_EMPTY;
                res_seg_reg    <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    res_pos_reg[i] <= '0;
                    res_vel_reg[i] <= '0;
                end
            end
            DP_RD_LAST:
                row_a_reg <= rd_row_reg;
            DP_HOLD_FIRST, DP_HOLD_LAST:
            begin
                res_status_reg <= ST_OK;
                if (ctl.op == DP_HOLD_FIRST)
                begin
                    res_seg_reg    <= '0;
                    res_pos_reg[0] <= row_a_reg.pos_x;
                    res_pos_reg[1] <= row_a_reg.pos_y;
                    res_pos_reg[2] <= row_a_reg.pos_z;
                    res_vel_reg[0] <= row_a_reg.vel_x;
                    res_vel_reg[1] <= row_a_reg.vel_y;
                    res_vel_reg[2] <= row_a_reg.vel_z;
                end
                else
                begin
                    res_seg_reg    <= 10'(n_cur - CW'(1));
                    res_pos_reg[0] <= rd_row_reg.pos_x;
                    res_pos_reg[1] <= rd_row_reg.pos_y;
                    res_pos_reg[2] <= rd_row_reg.pos_z;
                    res_vel_reg[0] <= rd_row_reg.vel_x;
                    res_vel_reg[1] <= rd_row_reg.vel_y;
                    res_vel_reg[2] <= rd_row_reg.vel_z;
                end
            end
            DP_WALK_INIT:
                idx_reg <= idx_init;
            DP_WALK_STEP:
                idx_reg <= idx_reg + IW'(1);
            DP_WALK_END:
            begin
                row_b_reg      <= rd_row_reg;
                res_seg_reg    <= 10'(idx_reg);
                res_status_reg <= ST_OK;
            end
            DP_GET_A:
                row_a_reg <= rd_row_reg;
            DP_DIV_INIT:
            begin
                div_dvs_reg  <= dn;
                div_neg_reg  <= num[32] ^ den[32];
                div_zero_reg <= (den == '0);
                div_big_reg  <= {1'b0, an} >= {dn, 1'b0};
                if (an >= dn)
                begin
                    div_rem_reg <= an - dn;
                    div_q_reg   <= 17'd1;
                end
                else
                begin
                    div_rem_reg <= an;
                    div_q_reg   <= '0;
                end
            end
            DP_DIV_STEP:
                if (r2 >= {1'b0, div_dvs_reg})
                begin
                    div_rem_reg <= 33'(r2 - {1'b0, div_dvs_reg});
                    div_q_reg   <= {div_q_reg[15:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= 33'(r2);
                    div_q_reg   <= {div_q_reg[15:0], 1'b0};
                end
            DP_DIV_FIN:
                if (div_zero_reg)
                    f_reg <= '0;
                else if (div_neg_reg)
                    f_reg <= -$signed({1'b0, mag});
                else
                    f_reg <= $signed({1'b0, mag});
            DP_MUL_ISSUE:
                prod_reg <= ma * mb;
            DP_MUL_WB:
                case (ctl.mop)
                    M_T2:   t2_reg <= 18'(rnd_val);
                    M_T3:   t3_reg <= 18'(rnd_val);
                    M_WA:   wa_reg <= sat32(rnd54);
                    M_WB:   wb_reg <= sat32(rnd54);
                    M_P0:   acc_reg <= rnd54;
                    M_V0, M_P1:
                        acc_reg <= acc_reg + rnd54;
                    M_V1:   res_pos_reg[ctl.axis] <= sat32(acc_reg + rnd54);
                    M_LERP: res_vel_reg[ctl.axis] <= sat32(54'(v0) + rnd54);
                    default: ;
                endcase
            DP_COMMIT:
            begin
                out_status_reg <= res_status_reg;
                out_seg_reg    <= res_seg_reg;
                for (int i = 0; i < 3; i++)
                begin
                    out_pos_reg[i] <= res_pos_reg[i];
                    out_vel_reg[i] <= res_vel_reg[i];
                end
            end
            default: ;
        endcase
    end

    assign status    = out_status_reg;
    assign segment   = out_seg_reg;
    assign out_pos_x = out_pos_reg[0];
    assign out_pos_y = out_pos_reg[1];
    assign out_pos_z = out_pos_reg[2];
    assign out_vel_x = out_vel_reg[0];
    assign out_vel_y = out_vel_reg[1];
    assign out_vel_z = out_vel_reg[2];

endmodule

/* rtl/trajectory_hermite_interpolator.sv */
// operation: a load stores one sample row; a held query returns the first or last sample;
// an interpolated query walks the cursor (one memory read per cursor step), then runs
// a 17-bit restoring divide and 19 products through one shared multiplier
// throughput: one item at a time; the next is taken once the result is registered
// reset: sample counts and cursors clear at once, sample memory is not cleared
// top level of the trajectory hermite interpolator; depends on thi_pkg, thi_ctrl, thi_dp
module trajectory_hermite_interpolator #(
    parameter int BODIES  = 10,
    parameter int SAMPLES = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    // input transfer
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [3:0]         body,
    input  logic signed [31:0] sample_or_query_time,
    input  logic signed [31:0] in_pos_x,
    input  logic signed [31:0] in_pos_y,
    input  logic signed [31:0] in_pos_z,
    input  logic signed [31:0] in_vel_x,
    input  logic signed [31:0] in_vel_y,
    input  logic signed [31:0] in_vel_z,
    // result transfer
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic signed [31:0] out_vel_x,
    output logic signed [31:0] out_vel_y,
    output logic signed [31:0] out_vel_z,
    output logic [9:0]         segment
);
    import thi_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t  ctl;
    dp_stat_t stat;

    // sequencer: walks load, hold, cursor search, divide and product steps
    thi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .ctl       (ctl)
    );

    // datapath: sample memory, cursors, divider, multiplier, result register
    thi_dp #(
        .BODIES  (BODIES),
        .SAMPLES (SAMPLES)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .ctl                  (ctl),
        .stat                 (stat),
        .cmd                  (cmd),
        .body                 (body),
        .sample_or_query_time (sample_or_query_time),
        .in_pos_x             (in_pos_x),
        .in_pos_y             (in_pos_y),
        .in_pos_z             (in_pos_z),
        .in_vel_x             (in_vel_x),
        .in_vel_y             (in_vel_y),
        .in_vel_z             (in_vel_z),
        .status               (status),
        .out_pos_x            (out_pos_x),
        .out_pos_y            (out_pos_y),
        .out_pos_z            (out_pos_z),
        .out_vel_x            (out_vel_x),
        .out_vel_y            (out_vel_y),
        .out_vel_z            (out_vel_z),
        .segment              (segment)
    );

endmodule
